/* rtl/free_segment_allocator_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef FREE_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define FREE_SEGMENT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FSA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsa check failed: same-cycle implication");

// Next-cycle implication.
`define FSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsa check failed: next-cycle implication");

`endif

/* rtl/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// fsa_pkg
// Types, codes and defaults shared by the free segment allocator files.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int DEF_MAX_FREE_SEGMENTS = 64;
  localparam int DEF_MAX_LIVE_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES      = 16;
  localparam int DEF_MIN_SPLIT_BYTES   = 16;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 25;
  localparam int PAD_W   = 12;
  localparam int ALIGN_W = 13;
  // Wide enough for any table position up to 1024 entries plus one.
  localparam int POS_W   = 11;
  // Remainder pipeline: four address bits per stage.
  localparam int PAD_STAGES = 8;

  localparam logic [ADDR_W-1:0] RESET_ARENA_BASE  = 32'h0;
  localparam logic [SIZE_W-1:0] RESET_ARENA_BYTES = 25'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LSCAN, S_FSCAN, S_CALC, S_EDIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD, CM_ROTATE, CM_EDIT, CM_LOAD
  } cell_mode_t;

  typedef enum logic [1:0] {
    SH_NONE, SH_DOWN, SH_UP
  } shift_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    seg_t             wr_seg;
    shift_t           shift;
    logic [POS_W-1:0] sh_pos;
    seg_t             load_seg;
  } seg_cmd_t;

endpackage

/* rtl/fsa_ram.sv */
// ----------------------------------------------------------------------------
// fsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fsa_seg_cell.sv */
// ----------------------------------------------------------------------------
// fsa_seg_cell
// One free-segment entry of the ring; rotates, shifts, is written or loads on command.
// ----------------------------------------------------------------------------
module fsa_seg_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  fsa_pkg::seg_cmd_t cmd,
  input  fsa_pkg::seg_t    from_next,
  input  fsa_pkg::seg_t    from_prev,
  output fsa_pkg::seg_t    seg
);
  import fsa_pkg::*;

  localparam logic [POS_W-1:0] MY = POS_W'(IDX);
  localparam seg_t RST_SEG = (IDX == 0) ? {RESET_ARENA_BASE, RESET_ARENA_BYTES} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= RST_SEG;
    end else begin
      case (cmd.mode)
        CM_ROTATE: seg <= from_next;
        CM_LOAD:   seg <= (IDX == 0) ? cmd.load_seg : '0;
        CM_EDIT: begin
          if (cmd.wr_en && MY == cmd.wr_pos) begin
            seg <= cmd.wr_seg;
          end else if (cmd.shift == SH_DOWN && MY >= cmd.sh_pos) begin
            seg <= from_next;
          end else if (cmd.shift == SH_UP && MY > cmd.sh_pos) begin
            seg <= from_prev;
          end
        end
        default: seg <= seg;
      endcase
    end
  end

endmodule

/* rtl/fsa_pad_pipe.sv */
// ----------------------------------------------------------------------------
// fsa_pad_pipe
// Pipelined remainder of the header address by the alignment; yields padding.
// ----------------------------------------------------------------------------
module fsa_pad_pipe #(
  parameter int IDX_W        = 6,
  parameter int HEADER_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_v,
  input  fsa_pkg::seg_t               in_seg,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [fsa_pkg::ALIGN_W-1:0] align,
  output logic                        out_v,
  output fsa_pkg::seg_t               out_seg,
  output logic [IDX_W-1:0]            out_idx,
  output logic [fsa_pkg::PAD_W-1:0]   out_pad
);
  import fsa_pkg::*;

  logic               v_q    [PAD_STAGES];
  seg_t               seg_q  [PAD_STAGES];
  logic [IDX_W-1:0]   idx_q  [PAD_STAGES];
  logic [ALIGN_W-1:0] rem_q  [PAD_STAGES];
  logic [ADDR_W-1:0]  bits_q [PAD_STAGES];
  logic [ADDR_W-1:0]  hdr;

  function automatic logic [ALIGN_W-1:0] step4(input logic [ALIGN_W-1:0] r,
                                               input logic [3:0] nib,
                                               input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W:0]   t;
    logic [ALIGN_W-1:0] rr;
    rr = r;
    for (int k = 3; k >= 0; k--) begin
      t = {rr, nib[k]};
      if (t >= {1'b0, a}) t = t - {1'b0, a};
      rr = t[ALIGN_W-1:0];
    end
    return rr;
  endfunction

  assign hdr = in_seg.start + ADDR_W'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PAD_STAGES; s++) v_q[s] <= 1'b0;
    end else begin
      v_q[0] <= in_v;
      for (int s = 1; s < PAD_STAGES; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    seg_q[0]  <= in_seg;
    idx_q[0]  <= in_idx;
    rem_q[0]  <= step4('0, hdr[ADDR_W-1 -: 4], align);
    bits_q[0] <= hdr << 4;
    for (int s = 1; s < PAD_STAGES; s++) begin
      seg_q[s]  <= seg_q[s-1];
      idx_q[s]  <= idx_q[s-1];
      rem_q[s]  <= step4(rem_q[s-1], bits_q[s-1][ADDR_W-1 -: 4], align);
      bits_q[s] <= bits_q[s-1] << 4;
    end
  end

  assign out_v   = v_q[PAD_STAGES-1];
  assign out_seg = seg_q[PAD_STAGES-1];
  assign out_idx = idx_q[PAD_STAGES-1];
  assign out_pad = (rem_q[PAD_STAGES-1] == '0) ? '0
                 : PAD_W'(align - rem_q[PAD_STAGES-1]);

endmodule

/* rtl/free_segment_allocator_core.sv */
// ----------------------------------------------------------------------------
// free_segment_allocator_core
// Allocate/free makes one pass over the live-block RAM and one rotation of the
// segment ring through the 8-stage padding pipeline, then a calculate state, an
// edit state if the request can go ahead, and an output state. Arena reset goes
// straight to the edit state; free of address 0 and opcode 3 go straight to output.
// Synchronous reset restores one whole-arena segment; no clearing pass.
// ----------------------------------------------------------------------------
module free_segment_allocator_core #(
  parameter int MAX_FREE_SEGMENTS = fsa_pkg::DEF_MAX_FREE_SEGMENTS,
  parameter int MAX_LIVE_BLOCKS   = fsa_pkg::DEF_MAX_LIVE_BLOCKS,
  parameter int HEADER_BYTES      = fsa_pkg::DEF_HEADER_BYTES,
  parameter int MIN_SPLIT_BYTES   = fsa_pkg::DEF_MIN_SPLIT_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [24:0] request_bytes,
  input  logic [12:0] align_bytes,
  input  logic [31:0] release_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] user_address,
  output logic [24:0] used_bytes,
  output logic [24:0] peak_bytes
);
  import fsa_pkg::*;

  localparam int NF   = MAX_FREE_SEGMENTS;
  localparam int NL   = MAX_LIVE_BLOCKS;
  localparam int IW   = $clog2(NF);
  localparam int CW   = $clog2(NF + 1);
  localparam int LIW  = $clog2(NL);
  localparam int LCW  = $clog2(NL + 1);
  localparam int FCW  = $clog2(NF + PAD_STAGES);
  localparam int NW   = SIZE_W + 2;
  localparam int RW   = ADDR_W + SIZE_W + PAD_W;

  localparam logic [3:0] ADDR_BASE   = 4'h0;
  localparam logic [3:0] ADDR_BYTES  = 4'h4;
  localparam logic [3:0] ADDR_POLICY = 4'h8;

  // configuration
  logic [ADDR_W-1:0] arena_base;
  logic [SIZE_W-1:0] arena_bytes;
  logic              fit_policy;

  // control
  state_t          state, state_next;
  op_t             op;
  logic [LCW-1:0]  lcnt;
  logic [FCW-1:0]  fcnt;
  logic [CW-1:0]   count;

  // request
  logic [SIZE_W-1:0]  req;
  logic [ALIGN_W-1:0] align;
  logic [ADDR_W-1:0]  rel_addr;

  // live scan
  logic            ld_v, ld_live;
  logic [LIW-1:0]  ld_idx;
  logic [NL-1:0]   live_valid;
  logic            slot_found;
  logic [LIW-1:0]  slot;
  logic [ADDR_W-1:0] bstart;
  logic [SIZE_W:0]   bsize;

  // segment scan
  logic            found;
  seg_t            best_seg;
  logic [IW-1:0]   best_idx;
  logic [PAD_W-1:0] best_pad;
  logic            prev_v, next_v;
  seg_t            prev_seg, next_seg;
  logic [CW-1:0]   pos;

  // calculated edit
  logic              a_split;
  logic [SIZE_W-1:0] a_need, a_rest;
  logic [ADDR_W-1:0] a_newstart, a_uaddr;
  logic              f_jp, f_jn;
  logic [CW-1:0]     f_pos;

  logic [SIZE_W-1:0] used_total, peak_total;
  status_t           res_status;
  logic [ADDR_W-1:0] res_uaddr;

  // ring and pipe wiring
  seg_cmd_t   cmd;
  seg_t       segs [NF];
  logic       pp_v;
  seg_t       pp_seg;
  logic [IW-1:0] pp_idx;
  logic [PAD_W-1:0] pp_pad;

  // RAM
  logic           ram_we;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] rd_start;
  logic [SIZE_W-1:0] rd_bytes;
  logic [PAD_W-1:0]  rd_pad;

  // combinational helpers
  logic [NW-1:0]     need_c;
  logic              fit_c, take_c, pp_live;
  logic              calc_jp, calc_jn;
  logic [SIZE_W-1:0] used_add;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base  <= RESET_ARENA_BASE;
      arena_bytes <= RESET_ARENA_BYTES;
      fit_policy  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_BASE:   arena_base  <= pwdata;
        ADDR_BYTES:  arena_bytes <= pwdata[SIZE_W-1:0];
        ADDR_POLICY: fit_policy  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_BASE:   prdata = arena_base;
      ADDR_BYTES:  prdata = {7'b0, arena_bytes};
      ADDR_POLICY: prdata = {31'b0, fit_policy};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- ring
  for (genvar i = 0; i < NF; i++) begin : g_cell
    seg_t nxt, prv;
    if (i < NF - 1) begin : g_mid
      assign nxt = segs[i+1];
    end else begin : g_last
      assign nxt = (cmd.mode == CM_ROTATE) ? segs[0] : '0;
    end
    if (i > 0) begin : g_prv
      assign prv = segs[i-1];
    end else begin : g_first
      assign prv = '0;
    end
    fsa_seg_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .from_next(nxt), .from_prev(prv), .seg(segs[i])
    );
  end

  fsa_pad_pipe #(.IDX_W(IW), .HEADER_BYTES(HEADER_BYTES)) u_pad (
    .clk(clk), .rst(rst),
    .in_v(state == S_FSCAN && fcnt < FCW'(NF)),
    .in_seg(segs[0]), .in_idx(fcnt[IW-1:0]), .align(align),
    .out_v(pp_v), .out_seg(pp_seg), .out_idx(pp_idx), .out_pad(pp_pad)
  );

  fsa_ram #(.WIDTH(RW), .DEPTH(NL)) u_live (
    .clk(clk), .we(ram_we), .waddr(slot), .wdata(ram_wdata),
    .raddr(lcnt[LIW-1:0]), .rdata(ram_rdata)
  );

  assign {rd_start, rd_bytes, rd_pad} = ram_rdata;
  assign ram_we    = (state == S_EDIT) && (op == OP_ALLOC);
  assign ram_wdata = {a_uaddr, SIZE_W'(a_need - SIZE_W'(best_pad)), best_pad};

  // ---------------------------------------------------------------- datapath
  assign need_c  = NW'(pp_pad) + NW'(HEADER_BYTES) + NW'(req);
  assign pp_live = pp_v && (CW'(pp_idx) < count);
  assign fit_c   = {2'b0, pp_seg.size} >= need_c;
  assign take_c  = fit_c && (!found || (fit_policy && pp_seg.size < best_seg.size));

  assign calc_jp = prev_v && (prev_seg.start + ADDR_W'(prev_seg.size)) == bstart;
  assign calc_jn = next_v && (bstart + ADDR_W'(bsize)) == next_seg.start;
  assign used_add = used_total + a_need;

  always_comb begin
    cmd          = '0;
    cmd.mode     = CM_HOLD;
    cmd.shift    = SH_NONE;
    cmd.load_seg = {arena_base, arena_bytes};
    if (state == S_FSCAN && fcnt < FCW'(NF)) cmd.mode = CM_ROTATE;
    if (state == S_EDIT) begin
      case (op)
        OP_ALLOC: begin
          cmd.mode = CM_EDIT;
          if (a_split) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_pos = POS_W'(best_idx);
            cmd.wr_seg = {a_newstart, a_rest};
          end else begin
            cmd.shift  = SH_DOWN;
            cmd.sh_pos = POS_W'(best_idx);
          end
        end
        OP_FREE: begin
          cmd.mode  = CM_EDIT;
          cmd.wr_en = 1'b1;
          if (f_jp) begin
            cmd.wr_pos = POS_W'(f_pos - CW'(1));
            cmd.wr_seg = {prev_seg.start, SIZE_W'(prev_seg.size + SIZE_W'(bsize)
                          + (f_jn ? next_seg.size : '0))};
            if (f_jn) begin
              cmd.shift  = SH_DOWN;
              cmd.sh_pos = POS_W'(f_pos);
            end
          end else if (f_jn) begin
            cmd.wr_pos = POS_W'(f_pos);
            cmd.wr_seg = {bstart, SIZE_W'(next_seg.size + SIZE_W'(bsize))};
          end else begin
            cmd.wr_pos = POS_W'(f_pos);
            cmd.wr_seg = {bstart, SIZE_W'(bsize)};
            cmd.shift  = SH_UP;
            cmd.sh_pos = POS_W'(f_pos);
          end
        end
        OP_RESET: cmd.mode = CM_LOAD;
        default:  cmd.mode = CM_HOLD;
      endcase
    end
  end

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_ALLOC: state_next = S_LSCAN;
            OP_FREE:  state_next = (release_address == '0) ? S_DONE : S_LSCAN;
            OP_RESET: state_next = S_EDIT;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_LSCAN: if (lcnt == LCW'(NL)) state_next = S_FSCAN;
      S_FSCAN: if (fcnt == FCW'(NF + PAD_STAGES - 1)) state_next = S_CALC;
      S_CALC: begin
        if (op == OP_ALLOC) begin
          state_next = (found && slot_found) ? S_EDIT : S_DONE;
        end else if (!slot_found) begin
          state_next = S_DONE;
        end else if (!calc_jp && !calc_jn && count >= CW'(NF)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_EDIT;
        end
      end
      S_EDIT: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= CW'(1);
      live_valid <= '0;
      used_total <= '0;
      peak_total <= '0;
      out_valid  <= 1'b0;
      lcnt       <= '0;
      fcnt       <= '0;
      ld_v       <= 1'b0;
    end else begin
      ld_v <= (state == S_LSCAN) && (lcnt < LCW'(NL));
      if (state == S_IDLE) begin
        lcnt <= '0;
        fcnt <= '0;
      end
      if (state == S_LSCAN && lcnt != LCW'(NL)) lcnt <= lcnt + LCW'(1);
      if (state == S_FSCAN) fcnt <= fcnt + FCW'(1);
      if (state == S_EDIT) begin
        case (op)
          OP_ALLOC: begin
            live_valid[slot] <= 1'b1;
            if (!a_split) count <= count - CW'(1);
            used_total <= used_add;
            if (used_add > peak_total) peak_total <= used_add;
          end
          OP_FREE: begin
            live_valid[slot] <= 1'b0;
            if (f_jp && f_jn) count <= count - CW'(1);
            else if (!f_jp && !f_jn) count <= count + CW'(1);
            used_total <= ({1'b0, used_total} >= bsize) ? SIZE_W'({1'b0, used_total} - bsize)
                                                        : '0;
          end
          OP_RESET: begin
            live_valid <= '0;
            count      <= CW'(1);
            used_total <= '0;
            peak_total <= '0;
          end
          default: ;
        endcase
      end
      // load a new word when finished, drop the word once taken
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_idx  <= lcnt[LIW-1:0];
    ld_live <= live_valid[lcnt[LIW-1:0]];
    case (state)
      S_IDLE: begin
        op         <= op_t'(opcode);
        req        <= request_bytes;
        align      <= (align_bytes == '0) ? ALIGN_W'(1)
                    : (align_bytes > ALIGN_W'(4096)) ? ALIGN_W'(4096) : align_bytes;
        rel_addr   <= release_address;
        slot_found <= 1'b0;
        found      <= 1'b0;
        prev_v     <= 1'b0;
        next_v     <= 1'b0;
        res_status <= ST_OK;
        res_uaddr  <= '0;
      end
      S_LSCAN: begin
        if (ld_v && !slot_found) begin
          if (op == OP_ALLOC && !ld_live) begin
            slot_found <= 1'b1;
            slot       <= ld_idx;
          end else if (op == OP_FREE && ld_live && rd_start == rel_addr) begin
            slot_found <= 1'b1;
            slot       <= ld_idx;
            bstart     <= rel_addr - ADDR_W'(HEADER_BYTES) - ADDR_W'(rd_pad);
            bsize      <= (SIZE_W+1)'(rd_bytes) + (SIZE_W+1)'(rd_pad);
          end
        end
      end
      S_FSCAN: begin
        if (pp_live) begin
          if (op == OP_ALLOC) begin
            if (take_c) begin
              found    <= 1'b1;
              best_seg <= pp_seg;
              best_idx <= pp_idx;
              best_pad <= pp_pad;
            end
          end else if (!next_v) begin
            if (pp_seg.start < bstart) begin
              prev_v   <= 1'b1;
              prev_seg <= pp_seg;
            end else begin
              next_v   <= 1'b1;
              next_seg <= pp_seg;
              pos      <= CW'(pp_idx);
            end
          end
        end
      end
      S_CALC: begin
        if (op == OP_ALLOC) begin
          if (!found) begin
            res_status <= ST_NO_FIT;
          end else if (!slot_found) begin
            res_status <= ST_FULL;
          end else begin
            a_split    <= (SIZE_W'(best_seg.size - SIZE_W'(NW'(best_pad) + NW'(HEADER_BYTES)
                           + NW'(req)))) >= SIZE_W'(MIN_SPLIT_BYTES);
            // a short remainder goes with the block
            a_need     <= ((SIZE_W'(best_seg.size - SIZE_W'(NW'(best_pad)
                           + NW'(HEADER_BYTES) + NW'(req)))) < SIZE_W'(MIN_SPLIT_BYTES))
                        ? best_seg.size
                        : SIZE_W'(NW'(best_pad) + NW'(HEADER_BYTES) + NW'(req));
            a_rest     <= SIZE_W'(best_seg.size - SIZE_W'(NW'(best_pad)
                          + NW'(HEADER_BYTES) + NW'(req)));
            a_uaddr    <= best_seg.start + ADDR_W'(best_pad) + ADDR_W'(HEADER_BYTES);
            res_uaddr  <= best_seg.start + ADDR_W'(best_pad) + ADDR_W'(HEADER_BYTES);
          end
        end else begin
          f_jp  <= calc_jp;
          f_jn  <= calc_jn;
          f_pos <= next_v ? pos : count;
          if (!slot_found) res_status <= ST_UNKNOWN;
          else if (!calc_jp && !calc_jn && count >= CW'(NF)) res_status <= ST_FULL;
        end
      end
      S_EDIT: begin
        if (op == OP_ALLOC) begin
          a_newstart <= a_newstart;
          if (!a_split) a_need <= a_need;
        end
      end
      default: ;
    endcase
    // new start follows the calculated need
    if (state == S_CALC && op == OP_ALLOC) begin
      a_newstart <= best_seg.start + ADDR_W'(NW'(best_pad) + NW'(HEADER_BYTES) + NW'(req));
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status       <= res_status;
      user_address <= res_uaddr;
      used_bytes   <= used_total;
      peak_bytes   <= peak_total;
    end
  end

endmodule

/* rtl/fsa_checker.sv */
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "free_segment_allocator_core_macros.svh"

module fsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] user_address
);
  import fsa_pkg::*;

  // an accepted request takes the block out of idle, so in_ready drops
`FSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // only a successful allocate returns an address
`FSA_ASSERT_IMPLY(a_addr_zero_on_fail, out_valid && status != ST_OK, user_address == 32'h0)
  // hold a stalled result word
`FSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(user_address))

endmodule

bind free_segment_allocator_core fsa_checker u_fsa_checker (.*);
